### sv/ssa_attachment_uudecode_defines.svh
// assertion macros for the attachment decoder checker
`ifndef SSA_ATTACHMENT_UUDECODE_DEFINES_SVH
`define SSA_ATTACHMENT_UUDECODE_DEFINES_SVH

// property checked at every edge outside reset
`define SSA_UUD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define SSA_UUD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/ssa_uud_pkg.sv
// types and constants shared by the attachment decoder modules
`timescale 1ns / 1ps
package ssa_uud_pkg;

   localparam logic [7:0] CHAR_OFFSET = 8'd33;
   localparam logic [1:0] GROUP_FULL  = 2'd3;
   localparam logic [1:0] PEND_ONE    = 2'd2;
   localparam logic [1:0] PEND_TWO    = 2'd3;
   localparam logic [1:0] NBYTES_ONE  = 2'd1;
   localparam logic [1:0] NBYTES_TWO  = 2'd2;
   localparam logic [1:0] NBYTES_FULL = 2'd3;

   typedef struct packed {
      logic [7:0] text_char;
      logic       final_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       attachment_end;
   } rsp_type;

   // one decoded group: up to three bytes, first byte in data[0]
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      nbytes;
      logic            fin;
   } job_type;

endpackage

### sv/ssa_attachment_uudecode.sv
// top level of the offset-33 attachment text decoder
`timescale 1ns / 1ps
// Decodes subtitle attachment text: each character minus 33 gives a sextet,
// four sextets give three bytes, most significant bits first. On the
// character marked final, two or three pending sextets give one or two bytes
// and a lone sextet is dropped; the decoder then starts clean. One character
// is accepted per cycle while the job queue (QUEUE_DEPTH entries) has room;
// the back end sends one byte per cycle from its output register while
// rsp_ready is held, so the sustained input rate is one character per cycle
// for normal text while the output does not stall. The first byte of a
// group is registered in the job queue, the job register and rsp_ff.
module ssa_attachment_uudecode #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ssa_uud_pkg::req_type req,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ssa_uud_pkg::rsp_type rsp
);
   import ssa_uud_pkg::*;

   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;
   job_type push_data, pop_data;

   ssa_uud_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ssa_uud_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ssa_uud_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

### sv/ssa_uud_fifo.sv
// short job queue between the character front end and the byte back end
`timescale 1ns / 1ps
module ssa_uud_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ssa_uud_pkg::job_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ssa_uud_pkg::job_type pop_data
);
   import ssa_uud_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = queue_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/ssa_uud_front.sv
// front end: turns characters into sextets and packs groups into byte jobs
`timescale 1ns / 1ps
module ssa_uud_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ssa_uud_pkg::req_type req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output ssa_uud_pkg::job_type push_data
);
   import ssa_uud_pkg::*;

   logic [17:0] store_ff, store_in;
   logic [1:0]  count_ff, count_in;
   logic [7:0]  diff;
   logic [5:0]  sextet;
   logic [23:0] word;
   logic        accept;
   logic        has_bytes;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign diff       = req.text_char - CHAR_OFFSET;
   assign sextet     = diff[5:0];
   assign push_valid = req_valid && has_bytes;

   always_comb begin
      word           = {store_ff, sextet};
      store_in       = store_ff;
      count_in       = count_ff;
      has_bytes      = 1'b0;
      push_data      = '0;
      push_data.fin  = req.final_char;
      if (count_ff == GROUP_FULL) begin
         // fourth sextet closes a 24-bit group
         push_data.data[0] = word[23:16];
         push_data.data[1] = word[15:8];
         push_data.data[2] = word[7:0];
         push_data.nbytes  = NBYTES_FULL;
         has_bytes         = 1'b1;
         store_in          = '0;
         count_in          = '0;
      end else begin
         store_in = {store_ff[11:0], sextet};
         count_in = count_ff + 2'd1;
         if (req.final_char) begin
            if (count_in == PEND_ONE) begin
               push_data.data[0] = store_in[11:4];
               push_data.nbytes  = NBYTES_ONE;
               has_bytes         = 1'b1;
            end else if (count_in == PEND_TWO) begin
               push_data.data[0] = store_in[17:10];
               push_data.data[1] = store_in[9:2];
               push_data.nbytes  = NBYTES_TWO;
               has_bytes         = 1'b1;
            end
         end
      end
      if (req.final_char) begin
         store_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         store_ff <= store_in;
         count_ff <= count_in;
      end
   end

endmodule

### sv/ssa_uud_back.sv
// back end: sends the bytes of each job one beat at a time
`timescale 1ns / 1ps
module ssa_uud_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  ssa_uud_pkg::job_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ssa_uud_pkg::rsp_type rsp
);
   import ssa_uud_pkg::*;

   job_type    cur_ff;
   rsp_type    rsp_ff;
   logic       busy_ff;
   logic       rsp_valid_ff;
   logic [1:0] idx_ff;
   logic       advance;
   logic       last;
   logic [7:0] sel_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign last      = (idx_ff == cur_ff.nbytes - 2'd1);
   assign pop_ready = !busy_ff || (advance && last);

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = cur_ff.data[0];
         2'd1:    sel_byte = cur_ff.data[1];
         default: sel_byte = cur_ff.data[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= busy_ff;
         end
         if (pop_valid && pop_ready) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff && advance) begin
            idx_ff <= last ? 2'd0 : idx_ff + 2'd1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         cur_ff <= pop_data;
      end
      if (advance && busy_ff) begin
         rsp_ff.out_byte       <= sel_byte;
         rsp_ff.run_last       <= last;
         rsp_ff.attachment_end <= last && cur_ff.fin;
      end
   end

endmodule

### sv/ssa_uud_checker.sv
// port checker for the attachment decoder and its bind
`timescale 1ns / 1ps
`include "ssa_attachment_uudecode_defines.svh"
module ssa_uud_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input ssa_uud_pkg::req_type req,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ssa_uud_pkg::rsp_type rsp
);
   import ssa_uud_pkg::*;

   // stalled beat keeps its payload
   `SSA_UUD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp beat changed while stalled")
   // end of attachment only on the last byte of a group
   `SSA_UUD_ASSERT(a_end_last, rsp_valid |-> !rsp.attachment_end || rsp.run_last, "attachment_end without run_last")
   // bytes of one group leave back to back
   `SSA_UUD_ASSERT(a_run_cont, rsp_valid && rsp_ready && !rsp.run_last |=> rsp_valid, "gap inside a group")
   // nothing comes out right after reset
   `SSA_UUD_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

bind ssa_attachment_uudecode ssa_uud_checker u_chk (.*);

### tb/ssa_uud_byte_checker.sv
// watches the decoder channels, predicts the decoded bytes and compares them
`timescale 1ns / 1ps
module ssa_uud_byte_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  ssa_uud_pkg::req_type req,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ssa_uud_pkg::rsp_type rsp,
   output int                   fail_count,
   output int                   pending_count
);
   import ssa_uud_pkg::*;

   logic [17:0] sextet_bits;
   logic [1:0]  pending_sextets;
   rsp_type     expected_bytes[$];

   task automatic decode_char(input req_type beat);
      logic [7:0]  diff;
      logic [5:0]  sextet;
      logic [23:0] word;
      logic [7:0]  decoded[3];
      rsp_type     result;
      int          n;
      diff = beat.text_char - CHAR_OFFSET;
      sextet = diff[5:0];
      n = 0;
      if (pending_sextets == GROUP_FULL) begin
         word = {sextet_bits, sextet};
         decoded[0] = word[23:16];
         decoded[1] = word[15:8];
         decoded[2] = word[7:0];
         n = NBYTES_FULL;
         sextet_bits = '0;
         pending_sextets = '0;
      end else begin
         sextet_bits = {sextet_bits[11:0], sextet};
         pending_sextets = pending_sextets + 2'd1;
         if (beat.final_char) begin
            if (pending_sextets == PEND_ONE) begin
               decoded[0] = sextet_bits[11:4];
               n = NBYTES_ONE;
            end else if (pending_sextets == PEND_TWO) begin
               decoded[0] = sextet_bits[17:10];
               decoded[1] = sextet_bits[9:2];
               n = NBYTES_TWO;
            end
         end
      end
      if (beat.final_char) begin
         sextet_bits = '0;
         pending_sextets = '0;
      end
      for (int i = 0; i < n; i++) begin
         result.out_byte = decoded[i];
         result.run_last = (i == n - 1);
         result.attachment_end = (i == n - 1) && beat.final_char;
         expected_bytes.push_back(result);
      end
   endtask

   task automatic compare_beat(input rsp_type actual);
      rsp_type want;
      if (expected_bytes.size() == 0) begin
         $error("rsp beat with no byte expected: out_byte %0h run_last %0b attachment_end %0b",
                actual.out_byte, actual.run_last, actual.attachment_end);
         fail_count++;
      end else begin
         want = expected_bytes.pop_front();
         if (actual.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, actual.out_byte);
            fail_count++;
         end
         if (actual.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, actual.run_last);
            fail_count++;
         end
         if (actual.attachment_end !== want.attachment_end) begin
            $error("attachment_end: expected %0b, got %0b",
                   want.attachment_end, actual.attachment_end);
            fail_count++;
         end
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      sextet_bits = '0;
      pending_sextets = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         sextet_bits = '0;
         pending_sextets = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_beat(rsp);
         if (req_valid && req_ready) decode_char(req);
      end
      pending_count = expected_bytes.size();
   end

endmodule

### tb/tb_ssa_attachment_uudecode.sv
// testbench top for the attachment decoder: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_ssa_attachment_uudecode;
   import ssa_uud_pkg::*;

   localparam int CHAR_TARGET = 400;
   localparam int CALM_FROM   = 340;
   localparam int STALL_LIMIT = 2000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp;
   int      fail_count;
   int      pending_count;
   int      chars_sent;
   int      stall_cycles;
   bit      calm;

   ssa_attachment_uudecode i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   ssa_uud_byte_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req           (req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_char(input logic [7:0] text, input logic last);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req.text_char = text;
      req.final_char = last;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
      if (chars_sent >= CALM_FROM) calm = 1'b1;
      @(negedge clock);
   endtask

   task automatic send_attachment(input int len);
      for (int i = 0; i < len; i++)
         send_char(8'($urandom_range(33, 96)), i == len - 1);
   endtask

   task automatic send_noise(input int len);
      for (int i = 0; i < len; i++)
         send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      chars_sent = 0;
      calm = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full groups at the range limits, then out-of-range characters
      send_char(8'd33, 1'b0);
      send_char(8'd33, 1'b0);
      send_char(8'd33, 1'b0);
      send_char(8'd96, 1'b0);
      repeat (4) send_char(8'd96, 1'b0);
      send_char(8'd0, 1'b0);
      send_char(8'd255, 1'b0);
      send_char(8'd128, 1'b0);
      send_char(8'd127, 1'b0);
      // lone sextet on final is dropped
      send_char(8'd65, 1'b1);
      // two and three leftover sextets
      send_char(8'd70, 1'b0);
      send_char(8'd80, 1'b1);
      send_char(8'd90, 1'b0);
      send_char(8'd40, 1'b0);
      send_char(8'd50, 1'b1);
      // final closing a full group
      send_char(8'd60, 1'b0);
      send_char(8'd61, 1'b0);
      send_char(8'd62, 1'b0);
      send_char(8'd63, 1'b1);

      while (chars_sent < CHAR_TARGET) begin
         if ($urandom_range(0, 99) < 85) send_attachment($urandom_range(1, 24));
         else send_noise($urandom_range(1, 8));
      end
      req_valid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
